@@ rtl/tpsa_pkg.sv @@
package tpsa_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ROT_WIDTH   = 18;
  localparam int ROT_FRAC    = 16;
  localparam int ROW_W       = 3 * ROT_WIDTH;
  localparam int CFG_W       = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH;

  // products, three-term sums with rounding bias, then the placed value before saturation
  localparam int PROD_W  = COORD_WIDTH + ROT_WIDTH;
  localparam int SUM_W   = PROD_W + 2;
  localparam int PLACE_W = SUM_W - ROT_FRAC + 1;

  localparam int MID_DEPTH = 8;
  localparam int RES_DEPTH = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_TRANS_X = 3'd3,
    REG_TRANS_Y = 3'd4,
    REG_TRANS_Z = 3'd5
  } cfg_reg_e;

  localparam logic [ROW_W-1:0] ROT_X_RESET = ROW_W'(1) << ROT_FRAC;
  localparam logic [ROW_W-1:0] ROT_Y_RESET = ROW_W'(1) << (ROT_FRAC + ROT_WIDTH);
  localparam logic [ROW_W-1:0] ROT_Z_RESET = ROW_W'(1) << (ROT_FRAC + 2 * ROT_WIDTH);

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_vertex;
  } point_t;

  typedef struct packed {
    coord_t box_xmin;
    coord_t box_xmax;
    coord_t box_ymin;
    coord_t box_ymax;
    coord_t box_zmin;
    coord_t box_zmax;
  } box_t;

  // one placed vertex between front and back
  typedef struct packed {
    coord_t wx;
    coord_t wy;
    coord_t wz;
    logic   last;
  } placed_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] rot;
    logic [2:0][COORD_WIDTH-1:0] trans;
  } xform_t;

endpackage

@@ rtl/tpsa_cfg.sv @@
module tpsa_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [tpsa_pkg::CFG_W-1:0] cfg_data,
  output tpsa_pkg::xform_t        xform
);
  import tpsa_pkg::*;

  xform_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rot[0]   <= ROT_X_RESET;
      regs.rot[1]   <= ROT_Y_RESET;
      regs.rot[2]   <= ROT_Z_RESET;
      regs.trans[0] <= '0;
      regs.trans[1] <= '0;
      regs.trans[2] <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_ROT_X:   regs.rot[0]   <= cfg_data[ROW_W-1:0];
        REG_ROT_Y:   regs.rot[1]   <= cfg_data[ROW_W-1:0];
        REG_ROT_Z:   regs.rot[2]   <= cfg_data[ROW_W-1:0];
        REG_TRANS_X: regs.trans[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_TRANS_Y: regs.trans[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_TRANS_Z: regs.trans[2] <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign xform = regs;

endmodule

@@ rtl/tpsa_front.sv @@
module tpsa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tpsa_pkg::point_t   in_point,
  input  tpsa_pkg::xform_t   xform,
  output logic               out_valid,
  output tpsa_pkg::placed_t  out_item
);
  import tpsa_pkg::*;

  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PLACE_W-1:0] place_t;

  localparam sum_t   ROUND_BIAS = sum_t'(1) <<< (ROT_FRAC - 1);
  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  coord_t pin [3];
  prod_t  prod [3][3];
  sum_t   sum [3];
  place_t placed [3];
  coord_t sat [3];
  coord_t wout [3];
  logic   v1, v2, v3;
  logic   l1, l2, l3;

  assign pin[0] = in_point.point_x;
  assign pin[1] = in_point.point_y;
  assign pin[2] = in_point.point_z;

  // stage 3 logic: drop rotation fraction (rounded), add translation, clamp
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      placed[a] = place_t'(sum[a] >>> ROT_FRAC) + place_t'($signed(xform.trans[a]));
      if (placed[a] > place_t'(CMAX))
        sat[a] = CMAX;
      else if (placed[a] < place_t'(CMIN))
        sat[a] = CMIN;
      else
        sat[a] = coord_t'(placed[a]);
    end
  end

  // no stall: the top level only admits items the queue can absorb
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    l1 <= in_point.last_vertex;
    l2 <= l1;
    l3 <= l2;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        prod[a][i] <= prod_t'($signed(xform.rot[a][i*ROT_WIDTH +: ROT_WIDTH]))
                      * prod_t'(pin[i]);
      end
      sum[a]  <= sum_t'(prod[a][0]) + sum_t'(prod[a][1]) + sum_t'(prod[a][2]) + ROUND_BIAS;
      wout[a] <= sat[a];
    end
  end

  assign out_valid     = v3;
  assign out_item.wx   = wout[0];
  assign out_item.wy   = wout[1];
  assign out_item.wz   = wout[2];
  assign out_item.last = l3;

endmodule

@@ rtl/tpsa_queue.sv @@
module tpsa_queue #(
  parameter int  DEPTH  = 2,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output logic  empty,
  output logic  full
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      mem[wr_ptr] <= din;
  end

endmodule

@@ rtl/tpsa_back.sv @@
module tpsa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_empty,
  input  tpsa_pkg::placed_t mid_item,
  output logic              mid_pop,
  input  logic              res_full,
  output logic              res_push,
  output tpsa_pkg::box_t    res_box
);
  import tpsa_pkg::*;

  coord_t run_min [3];
  coord_t run_max [3];
  coord_t w [3];
  coord_t min_next [3];
  coord_t max_next [3];
  logic   started;

  assign w[0] = mid_item.wx;
  assign w[1] = mid_item.wy;
  assign w[2] = mid_item.wz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      min_next[a] = (!started || w[a] < run_min[a]) ? w[a] : run_min[a];
      max_next[a] = (!started || w[a] > run_max[a]) ? w[a] : run_max[a];
    end
  end

  // only a closing vertex needs room in the result queue
  assign mid_pop  = !mid_empty && (!mid_item.last || !res_full);
  assign res_push = mid_pop && mid_item.last;

  assign res_box.box_xmin = min_next[0];
  assign res_box.box_xmax = max_next[0];
  assign res_box.box_ymin = min_next[1];
  assign res_box.box_ymax = max_next[1];
  assign res_box.box_zmin = min_next[2];
  assign res_box.box_zmax = max_next[2];

  always_ff @(posedge clk) begin
    if (rst)
      started <= 1'b0;
    else if (mid_pop)
      started <= !mid_item.last;
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      for (int a = 0; a < 3; a++) begin
        run_min[a] <= min_next[a];
        run_max[a] <= max_next[a];
      end
    end
  end

endmodule

@@ rtl/transformed_point_set_aabb.sv @@
// A box reaches the result ports once the last vertex has passed the front stages, the vertex queue and the back end.
// Throughput: one vertex per cycle while full is low; the 3-stage multiply/add front runs on credits
// against the QUEUE_DEPTH-entry queue ahead of the min/max back end.
// Reset (rst, synchronous, active high) restores identity rotation and zero translation,
// empties both queues and drops any partial set.
module transformed_point_set_aabb #(
  parameter int QUEUE_DEPTH = tpsa_pkg::MID_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  tpsa_pkg::point_t           point,
  output logic                       empty,
  input  logic                       pop,
  output tpsa_pkg::box_t             box,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [tpsa_pkg::CFG_W-1:0] cfg_data
);
  import tpsa_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  xform_t           xform;
  logic             accept;
  logic             front_valid;
  placed_t          front_item;
  logic             mid_empty, mid_pop;
  placed_t          mid_item;
  logic             res_full, res_push;
  box_t             res_box;
  logic [OCC_W-1:0] occ;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign full      = (occ == OCC_W'(QUEUE_DEPTH));

  // vertices in the front pipeline plus those waiting in the queue
  always_ff @(posedge clk) begin
    if (rst)
      occ <= '0;
    else if (accept && !mid_pop)
      occ <= occ + 1'b1;
    else if (mid_pop && !accept)
      occ <= occ - 1'b1;
  end

  tpsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .xform     (xform)
  );

  tpsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_point  (point),
    .xform     (xform),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  tpsa_queue #(.DEPTH(QUEUE_DEPTH), .item_t(placed_t)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_item),
    .pop   (mid_pop),
    .dout  (mid_item),
    .empty (mid_empty),
    .full  ()
  );

  tpsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_box   (res_box)
  );

  tpsa_queue #(.DEPTH(RES_DEPTH), .item_t(box_t)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_box),
    .pop   (pop),
    .dout  (box),
    .empty (empty),
    .full  (res_full)
  );

endmodule

@@ rtl/tpsa_checker.sv @@
module tpsa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input tpsa_pkg::point_t           point,
  input logic                       empty,
  input logic                       pop,
  input tpsa_pkg::box_t             box,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [2:0]                 cfg_index,
  input logic [tpsa_pkg::CFG_W-1:0] cfg_data
);
  import tpsa_pkg::*;

  // reset leaves both sides drained
  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !full && empty)
    else $error("queue state not cleared by reset");

  // a waiting box holds until transferred
  a_box_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(box))
    else $error("result changed before transfer");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> box.box_xmin <= box.box_xmax && box.box_ymin <= box.box_ymax
               && box.box_zmin <= box.box_zmax)
    else $error("box minimum above maximum");

  // no box can appear from nowhere right after reset
  a_no_early_box: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |=> empty)
    else $error("box shown too soon after reset");

endmodule

bind transformed_point_set_aabb tpsa_checker u_tpsa_checker (.*);
